FILE: sv/mono_frame_draw_engine_defines.svh
// Assertion macros for the RTL.
`ifndef MONO_FRAME_DRAW_ENGINE_DEFINES_SVH
`define MONO_FRAME_DRAW_ENGINE_DEFINES_SVH

`ifndef SYNTH
`define MFDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFDE_ASSERT(lbl, prop, msg)
`define MFDE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/mfde_pkg.sv
package mfde_pkg;

  typedef enum logic [2:0] {
    FN_POINT  = 3'd0,
    FN_LINE   = 3'd1,
    FN_RECT   = 3'd2,
    FN_FILL   = 3'd3,
    FN_CIRCLE = 3'd4,
    FN_CLEAR  = 3'd5,
    FN_READ   = 3'd6,
    FN_NOP    = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_CLEAR,
    S_INIT,
    S_PIX,
    S_WR,
    S_READ,
    S_RWAIT,
    S_DONE
  } state_t;

  // circle decision variable width
  localparam int D_W = 13;
  localparam int C_D0     = 3;
  localparam int C_STEP_A = 6;
  localparam int C_STEP_B = 10;
  localparam int C_GAIN   = 4;

  typedef struct packed {
    logic load;
    logic seg_init;
    logic seg_next;
    logic pix_rd;
    logic pix_wr;
    logic adv;
    logic clr_wr;
    logic rd_issue;
    logic rd_capture;
  } mfde_cmd_t;

  typedef struct packed {
    logic pix_ok;
    logic gen_last;
    logic seg_last;
    logic fill_empty;
    logic clr_last;
  } mfde_sts_t;

endpackage

FILE: sv/mfde_ctrl.sv
`include "mono_frame_draw_engine_defines.svh"

module mfde_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         in_func,
  input  mfde_pkg::mfde_sts_t sts,
  output mfde_pkg::mfde_cmd_t cmd,
  output logic               busy,
  output logic               out_valid
);
  import mfde_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // shared exit of the pixel loop
  function automatic state_t pix_exit(input mfde_sts_t s, input state_t stay);
    state_t n;
    if (!s.gen_last) n = stay;
    else if (s.seg_last) n = S_DONE;
    else n = S_INIT;
    return n;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_BOOT:  if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (func_t'(in_func))
            FN_POINT, FN_LINE, FN_RECT, FN_FILL, FN_CIRCLE: state_nxt = S_INIT;
            FN_CLEAR: state_nxt = S_CLEAR;
            FN_READ:  state_nxt = S_READ;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: if (sts.clr_last) state_nxt = S_DONE;
      S_INIT:  state_nxt = sts.fill_empty ? S_DONE : S_PIX;
      S_PIX:   state_nxt = sts.pix_ok ? S_WR : pix_exit(sts, S_PIX);
      S_WR:    state_nxt = pix_exit(sts, S_PIX);
      S_READ:  state_nxt = S_RWAIT;
      S_RWAIT: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_BOOT, S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_INIT: cmd.seg_init = 1'b1;
      S_PIX: begin
        cmd.pix_rd   = sts.pix_ok;
        cmd.adv      = !sts.pix_ok;
        cmd.seg_next = !sts.pix_ok && sts.gen_last && !sts.seg_last;
      end
      S_WR: begin
        cmd.pix_wr   = 1'b1;
        cmd.adv      = 1'b1;
        cmd.seg_next = sts.gen_last && !sts.seg_last;
      end
      S_READ:  cmd.rd_issue = 1'b1;
      S_RWAIT: cmd.rd_capture = 1'b1;
      S_DONE:  out_valid = 1'b1;
      default: ;
    endcase
  end

  `MFDE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command did not raise busy")
  `MFDE_ASSERT(a_done_idle, out_valid |=> !busy, "result not followed by idle")
  `MFDE_ASSERT(a_wr_after_rd, (state_r == S_WR) |-> $past(state_r == S_PIX),
               "pixel write without preceding read")

endmodule

FILE: sv/mfde_dp.sv
module mfde_dp #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mfde_pkg::mfde_cmd_t cmd,
  output mfde_pkg::mfde_sts_t sts,
  input  logic [2:0]         in_func,
  input  logic [7:0]         in_start_x,
  input  logic [7:0]         in_start_y,
  input  logic [7:0]         in_end_x,
  input  logic [7:0]         in_end_y,
  input  logic [7:0]         in_radius,
  input  logic               in_color,
  input  logic [2:0]         in_read_page,
  input  logic [6:0]         in_read_column,
  output logic [7:0]         out_read_data
);
  import mfde_pkg::*;

  localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_SIZE = PAGE_COUNT * DISPLAY_WIDTH;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  // command registers
  func_t      func_r;
  logic [7:0] x0_r, y0_r, x1_r, y1_r, rad_r;
  logic       color_r, rd_ok_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [7:0] rdata_q_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= func_t'(in_func);
      x0_r      <= in_start_x;
      y0_r      <= in_start_y;
      x1_r      <= in_end_x;
      y1_r      <= in_end_y;
      rad_r     <= in_radius;
      color_r   <= in_color;
      rd_ok_r   <= (32'(in_read_page) < PAGE_COUNT) && (32'(in_read_column) < DISPLAY_WIDTH);
      rd_addr_r <= ADDR_W'(32'(in_read_page) * DISPLAY_WIDTH + 32'(in_read_column));
    end
  end

  // segment select (rectangle outline has four)
  logic [1:0] seg_r;
  always_ff @(posedge clk) begin
    if (cmd.load) seg_r <= '0;
    else if (cmd.seg_next) seg_r <= seg_r + 2'd1;
  end

  logic [7:0] la_x, la_y, lb_x, lb_y;
  always_comb begin
    la_x = x0_r; la_y = y0_r; lb_x = x1_r; lb_y = y1_r;
    case (func_r)
      FN_POINT: begin
        lb_x = x0_r; lb_y = y0_r;
      end
      FN_RECT: begin
        case (seg_r)
          2'd0: begin la_x = x0_r; la_y = y0_r; lb_x = x1_r; lb_y = y0_r; end
          2'd1: begin la_x = x0_r; la_y = y0_r; lb_x = x0_r; lb_y = y1_r; end
          2'd2: begin la_x = x0_r; la_y = y1_r; lb_x = x1_r; lb_y = y1_r; end
          default: begin la_x = x1_r; la_y = y0_r; lb_x = x1_r; lb_y = y1_r; end
        endcase
      end
      default: ;
    endcase
  end

  // line stepper
  logic [7:0] cx_r, cy_r, adx_r, ady_r, dist_r, ex_r, ey_r;
  logic       nx_r, ny_r;
  logic [8:0] t_r;
  logic [8:0] dxs, dys, ex_s, ey_s;
  logic [7:0] adx, ady;

  assign dxs  = {1'b0, lb_x} - {1'b0, la_x};
  assign dys  = {1'b0, lb_y} - {1'b0, la_y};
  assign adx  = dxs[8] ? 8'(-dxs) : dxs[7:0];
  assign ady  = dys[8] ? 8'(-dys) : dys[7:0];
  assign ex_s = {1'b0, ex_r} + {1'b0, adx_r};
  assign ey_s = {1'b0, ey_r} + {1'b0, ady_r};

  // circle stepper
  logic signed [8:0]     ca_r, cb_r, ca_n, cb_n;
  logic signed [D_W-1:0] cd_r, cd_n;
  logic [2:0]            oct_r;

  assign ca_n = ca_r + 9'sd1;
  always_comb begin
    if (cd_r < 0) begin
      cd_n = cd_r + (D_W'(ca_n) * D_W'(C_GAIN)) + D_W'(C_STEP_A);
      cb_n = cb_r;
    end else begin
      cd_n = cd_r + D_W'(C_STEP_B) + (D_W'(ca_n - cb_r) * D_W'(C_GAIN));
      cb_n = cb_r - 9'sd1;
    end
  end

  // fill scanner
  logic [7:0] fi_r, fj_r;

  always_ff @(posedge clk) begin
    if (cmd.seg_init) begin
      cx_r   <= la_x;
      cy_r   <= la_y;
      adx_r  <= adx;
      ady_r  <= ady;
      nx_r   <= dxs[8];
      ny_r   <= dys[8];
      dist_r <= (adx > ady) ? adx : ady;
      ex_r   <= '0;
      ey_r   <= '0;
      t_r    <= '0;
      ca_r   <= '0;
      cb_r   <= $signed({1'b0, rad_r});
      cd_r   <= D_W'(C_D0) - (D_W'($signed({1'b0, rad_r})) * D_W'(2));
      oct_r  <= '0;
      fi_r   <= x0_r;
      fj_r   <= y0_r;
    end else if (cmd.adv) begin
      t_r <= t_r + 9'd1;
      if (ex_s > {1'b0, dist_r}) begin
        ex_r <= 8'(ex_s - {1'b0, dist_r});
        cx_r <= nx_r ? cx_r - 8'd1 : cx_r + 8'd1;
      end else begin
        ex_r <= ex_s[7:0];
      end
      if (ey_s > {1'b0, dist_r}) begin
        ey_r <= 8'(ey_s - {1'b0, dist_r});
        cy_r <= ny_r ? cy_r - 8'd1 : cy_r + 8'd1;
      end else begin
        ey_r <= ey_s[7:0];
      end
      oct_r <= oct_r + 3'd1;
      if (oct_r == 3'd7) begin
        ca_r <= ca_n;
        cb_r <= cb_n;
        cd_r <= cd_n;
      end
      if (fj_r == y1_r - 8'd1) begin
        fj_r <= y0_r;
        fi_r <= fi_r + 8'd1;
      end else begin
        fj_r <= fj_r + 8'd1;
      end
    end
  end

  // current pixel
  logic [7:0] px, py, a8, b8;
  assign a8 = ca_r[7:0];
  assign b8 = cb_r[7:0];
  always_comb begin
    case (func_r)
      FN_CIRCLE: begin
        case (oct_r)
          3'd0: begin px = x0_r + a8; py = y0_r - b8; end
          3'd1: begin px = x0_r + b8; py = y0_r - a8; end
          3'd2: begin px = x0_r + b8; py = y0_r + a8; end
          3'd3: begin px = x0_r + a8; py = y0_r + b8; end
          3'd4: begin px = x0_r - a8; py = y0_r + b8; end
          3'd5: begin px = x0_r - b8; py = y0_r + a8; end
          3'd6: begin px = x0_r - a8; py = y0_r - b8; end
          default: begin px = x0_r - b8; py = y0_r - a8; end
        endcase
      end
      FN_FILL: begin px = fi_r; py = fj_r; end
      default: begin px = cx_r; py = cy_r; end
    endcase
  end

  always_comb begin
    sts.pix_ok = (32'(px) < DISPLAY_WIDTH) && (32'(py) < DISPLAY_HEIGHT);
    case (func_r)
      FN_CIRCLE: sts.gen_last = (oct_r == 3'd7) && (ca_n > cb_n);
      FN_FILL:   sts.gen_last = (fi_r == x1_r - 8'd1) && (fj_r == y1_r - 8'd1);
      default:   sts.gen_last = (t_r == {1'b0, dist_r} + 9'd1);
    endcase
    sts.seg_last   = (func_r != FN_RECT) || (seg_r == 2'd3);
    sts.fill_empty = (func_r == FN_FILL) && ((x1_r <= x0_r) || (y1_r <= y0_r));
  end

  // frame store
  logic [7:0]        mem [STORE_SIZE];
  logic [ADDR_W-1:0] pix_addr, wr_addr_r, clr_cnt_r, raddr, waddr;
  logic [7:0]        rdata_r, bit_r, wdata;
  logic              we;

  assign pix_addr = ADDR_W'(32'(py[7:3]) * DISPLAY_WIDTH + 32'(px));
  assign sts.clr_last = (32'(clr_cnt_r) == STORE_SIZE - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_rd) begin
      wr_addr_r <= pix_addr;
      bit_r     <= 8'd1 << py[2:0];
    end
  end

  assign raddr = cmd.rd_issue ? rd_addr_r : pix_addr;
  assign we    = cmd.clr_wr || cmd.pix_wr;
  assign waddr = cmd.clr_wr ? clr_cnt_r : wr_addr_r;
  always_comb begin
    if (cmd.clr_wr) wdata = '0;
    else if (color_r) wdata = rdata_r | bit_r;
    else wdata = rdata_r & ~bit_r;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) rdata_q_r <= '0;
    else if (cmd.rd_capture) rdata_q_r <= rd_ok_r ? rdata_r : '0;
  end

  assign out_read_data = rdata_q_r;

endmodule

FILE: sv/mono_frame_draw_engine.sv
// Monochrome frame store with a draw engine. A command is taken when start
// is high and busy is low; exactly one result follows, shown for a single
// cycle with out_valid high, and it cannot be held off. Pixel work is a
// read-modify-write on the frame store: an on-screen pixel is read in S_PIX
// and written in S_WR, a clipped pixel is only stepped past in S_PIX, and
// each line (each of a rectangle's four) opens with a setup state, S_INIT. A
// line visits max(|dx|,|dy|)+2 pixels, a rectangle four such lines, a circle
// 8 pixels per step, a fill (x1-x0)*(y1-y0) pixels. Clear writes one byte a
// cycle, all ceil(DISPLAY_HEIGHT/8)*DISPLAY_WIDTH bytes, then the result;
// the same clearing pass runs after reset, with busy high. A read shows its
// byte with the result; an unused code has its result in the next cycle.
module mono_frame_draw_engine #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_func,
  input  logic [7:0] in_start_x,
  input  logic [7:0] in_start_y,
  input  logic [7:0] in_end_x,
  input  logic [7:0] in_end_y,
  input  logic [7:0] in_radius,
  input  logic       in_color,
  input  logic [2:0] in_read_page,
  input  logic [6:0] in_read_column,
  output logic       out_valid,
  output logic [7:0] out_read_data
);
  import mfde_pkg::*;

  mfde_cmd_t cmd;
  mfde_sts_t sts;

  mfde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mfde_dp #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_radius      (in_radius),
    .in_color       (in_color),
    .in_read_page   (in_read_page),
    .in_read_column (in_read_column),
    .out_read_data  (out_read_data)
  );

endmodule
